FILE: src/hsl_to_rgb_converter_core_defines.svh
// Assertion macros shared by the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HSL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsl converter assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsl converter assertion failed");

`endif

FILE: src/hsl_pkg.sv
// Package with the fixed-point constants and shared types of the HSL to RGB converter.
package hsl_pkg;

  localparam int FIELD_W   = 16;
  localparam int FRAC_BITS = 15;
  // Values in 0..1.0 need one bit above the fraction.
  localparam int VW        = FRAC_BITS + 1;

  localparam logic [VW-1:0]        ONE       = VW'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF      = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS-1:0] THIRD     = FRAC_BITS'((1 << FRAC_BITS) / 3);
  // Adding this constant modulo 1.0 subtracts one third.
  localparam logic [FRAC_BITS-1:0] NEG_THIRD = FRAC_BITS'((1 << FRAC_BITS) - (1 << FRAC_BITS) / 3);

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // Load enables of the inner pipeline stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

FILE: src/hsl_pq.sv
// Computes the q and p levels and their difference from saturation and lightness.
module hsl_pq import hsl_pkg::*; (
  input  logic          clk,
  input  pipe_en_t      en,
  input  logic [VW-1:0] sat_i,
  input  logic [VW-1:0] light_i,
  output logic [VW-1:0] q_o,
  output logic [VW-1:0] p_o,
  output logic [VW-1:0] d_o
);

  localparam int PW = 2 * VW + 1;
  localparam int SW = VW + 2;

  logic          lo_half;
  logic [VW:0]   mul_b;
  logic [PW-1:0] prod_nxt;

  logic [PW-1:0] prod_r;
  logic          lo_r;
  logic [VW-1:0] light2_r;
  logic [VW-1:0] sat2_r;

  logic [SW-1:0] prod_sh;
  logic [SW-1:0] q_full;
  logic [SW-1:0] p_full;
  logic [SW-1:0] d_full;

  logic [VW-1:0] q_r;
  logic [VW-1:0] p_r;
  logic [VW-1:0] d_r;

  // Below one half q is l*(1+s), otherwise l+s-l*s; one product covers both.
  assign lo_half  = (light_i < VW'(HALF));
  assign mul_b    = lo_half ? ((VW+1)'(ONE) + (VW+1)'(sat_i)) : (VW+1)'(sat_i);
  assign prod_nxt = PW'(light_i) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r   <= prod_nxt;
      lo_r     <= lo_half;
      light2_r <= light_i;
      sat2_r   <= sat_i;
    end
  end

  assign prod_sh = prod_r[PW-1:FRAC_BITS];
  assign q_full  = lo_r ? prod_sh : (SW'(light2_r) + SW'(sat2_r) - prod_sh);
  assign p_full  = {1'b0, light2_r, 1'b0} - q_full;
  assign d_full  = q_full - p_full;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      q_r <= q_full[VW-1:0];
      p_r <= p_full[VW-1:0];
      d_r <= d_full[VW-1:0];
    end
  end

  assign q_o = q_r;
  assign p_o = p_r;
  assign d_o = d_r;

endmodule

FILE: src/hsl_ramp.sv
// Evaluates the piecewise hue ramp for one color channel over three stages.
module hsl_ramp import hsl_pkg::*; (
  input  logic                 clk,
  input  pipe_en_t             en,
  input  logic [FRAC_BITS-1:0] t_i,
  input  logic [VW-1:0]        p_i,
  input  logic [VW-1:0]        q_i,
  input  logic [VW-1:0]        d_i,
  output logic [VW-1:0]        val_o
);

  localparam int T6W = FRAC_BITS + 3;
  localparam int PW  = 2 * VW;
  localparam int AW  = VW + 2;

  logic [FRAC_BITS-1:0] t2_r;

  logic [T6W-1:0] t6;
  logic [T6W-1:0] t3;
  logic [T6W-1:0] fall_x;
  seg_t           seg_nxt;
  logic [VW-1:0]  x_nxt;

  seg_t          seg3_r;
  logic [VW-1:0] x3_r;

  seg_t          seg4_r;
  logic [PW-1:0] prod4_r;
  logic [VW-1:0] p4_r;
  logic [VW-1:0] q4_r;

  logic [AW-1:0] sum;
  logic [AW-1:0] val;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      t2_r <= t_i;
    end
  end

  // Breakpoints are compared exactly: 6t < 1, 2t < 1 and 3t < 2.
  assign t6     = (T6W'(t2_r) << 2) + (T6W'(t2_r) << 1);
  assign t3     = (T6W'(t2_r) << 1) + T6W'(t2_r);
  assign fall_x = (T6W'(ONE) << 2) - t6;

  always_comb begin
    seg_nxt = SEG_LOW;
    x_nxt   = '0;
    priority if (t6 < T6W'(ONE)) begin
      seg_nxt = SEG_RISE;
      x_nxt   = t6[VW-1:0];
    end else if (t2_r < HALF) begin
      seg_nxt = SEG_HIGH;
    end else if (t3 < (T6W'(ONE) << 1)) begin
      seg_nxt = SEG_FALL;
      x_nxt   = fall_x[VW-1:0];
    end else begin
      seg_nxt = SEG_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      seg3_r <= seg_nxt;
      x3_r   <= x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      seg4_r  <= seg3_r;
      prod4_r <= PW'(d_i) * PW'(x3_r);
      p4_r    <= p_i;
      q4_r    <= q_i;
    end
  end

  assign sum = AW'(p4_r) + AW'(prod4_r[PW-1:FRAC_BITS]);

  always_comb begin
    unique case (seg4_r)
      SEG_RISE: val = sum;
      SEG_FALL: val = sum;
      SEG_HIGH: val = AW'(q4_r);
      SEG_LOW:  val = AW'(p4_r);
      default:  val = AW'(p4_r);
    endcase
  end

  assign val_o = (val > AW'(ONE)) ? ONE : val[VW-1:0];

endmodule

FILE: src/hsl_to_rgb_converter_core.sv
// Top level of the pipelined HSL to RGB converter.
//
//   channel   ports                                        direction
//   input     in_valid, in_stall, in_hue/saturation/lightness  hue, sat, light in
//   result    out_valid, out_stall, out_red/green/blue      red, green, blue out
//
// One pixel is accepted per cycle while in_stall is low; each pixel's result
// moves through the stages below in order and leaves from the output register.
// The pipeline has five register stages: input, q/p product, q/p and
// segment, ramp product, and output.
// Reset clears only the valid bits; payload registers are not reset.
// Each stage loads whenever it is empty or its successor moves, so bubbles
// close up under an output stall and nothing is lost or repeated.
module hsl_to_rgb_converter_core import hsl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] in_hue,
  input  logic [FIELD_W-1:0] in_saturation,
  input  logic [FIELD_W-1:0] in_lightness,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_red,
  output logic [FIELD_W-1:0] out_green,
  output logic [FIELD_W-1:0] out_blue
);

  `include "hsl_to_rgb_converter_core_defines.svh"

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  pipe_en_t en;

  logic [VW-1:0]        sat_c;
  logic [VW-1:0]        light_c;
  logic [FRAC_BITS-1:0] hue_w;

  logic [VW-1:0]        sat1_r;
  logic [VW-1:0]        light1_r;
  logic                 zero1_r;
  logic [FRAC_BITS-1:0] t_red1_r;
  logic [FRAC_BITS-1:0] t_grn1_r;
  logic [FRAC_BITS-1:0] t_blu1_r;

  logic [VW-1:0] light2_r, light3_r, light4_r;
  logic          zero2_r, zero3_r, zero4_r;

  logic [VW-1:0] pq_q, pq_p, pq_d;
  logic [VW-1:0] red_val, grn_val, blu_val;

  logic [FIELD_W-1:0] red_r, grn_r, blu_r;

  assign rdy5     = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // Saturation and lightness above one saturate; hue wraps modulo one.
  assign sat_c   = (in_saturation > FIELD_W'(ONE)) ? ONE : in_saturation[VW-1:0];
  assign light_c = (in_lightness > FIELD_W'(ONE)) ? ONE : in_lightness[VW-1:0];
  assign hue_w   = in_hue[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sat1_r   <= sat_c;
      light1_r <= light_c;
      zero1_r  <= (sat_c == '0);
      t_red1_r <= hue_w + THIRD;
      t_grn1_r <= hue_w;
      t_blu1_r <= hue_w + NEG_THIRD;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      light2_r <= light1_r;
      zero2_r  <= zero1_r;
    end
    if (rdy3) begin
      light3_r <= light2_r;
      zero3_r  <= zero2_r;
    end
    if (rdy4) begin
      light4_r <= light3_r;
      zero4_r  <= zero3_r;
    end
  end

  hsl_pq u_pq (
    .clk     (clk),
    .en      (en),
    .sat_i   (sat1_r),
    .light_i (light1_r),
    .q_o     (pq_q),
    .p_o     (pq_p),
    .d_o     (pq_d)
  );

  hsl_ramp u_ramp_red (
    .clk   (clk),
    .en    (en),
    .t_i   (t_red1_r),
    .p_i   (pq_p),
    .q_i   (pq_q),
    .d_i   (pq_d),
    .val_o (red_val)
  );

  hsl_ramp u_ramp_grn (
    .clk   (clk),
    .en    (en),
    .t_i   (t_grn1_r),
    .p_i   (pq_p),
    .q_i   (pq_q),
    .d_i   (pq_d),
    .val_o (grn_val)
  );

  hsl_ramp u_ramp_blu (
    .clk   (clk),
    .en    (en),
    .t_i   (t_blu1_r),
    .p_i   (pq_p),
    .q_i   (pq_q),
    .d_i   (pq_d),
    .val_o (blu_val)
  );

  // With zero saturation every channel is the lightness itself.
  always_ff @(posedge clk) begin
    if (rdy5) begin
      red_r <= zero4_r ? FIELD_W'(light4_r) : FIELD_W'(red_val);
      grn_r <= zero4_r ? FIELD_W'(light4_r) : FIELD_W'(grn_val);
      blu_r <= zero4_r ? FIELD_W'(light4_r) : FIELD_W'(blu_val);
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = grn_r;
  assign out_blue  = blu_r;

  `HSL_ASSERT_NOW(a_stall_only_full, in_stall, v1_r && v2_r && v3_r && v4_r && out_valid_r)
  `HSL_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v1_r)
  `HSL_ASSERT_NOW(a_p_below_q, v3_r, pq_p <= pq_q)
  `HSL_ASSERT_NOW(a_out_range, out_valid, (out_red <= FIELD_W'(ONE)) && (out_green <= FIELD_W'(ONE)) && (out_blue <= FIELD_W'(ONE)))

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the pipelined HSL to RGB converter core.
`timescale 1ns / 1ps

module testbench;

  localparam int W = hsl_pkg::FIELD_W;
  localparam longint UNIT = longint'(1) << hsl_pkg::FRAC_BITS;
  localparam longint THIRD_OFF = UNIT / 3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_SHOWN = 40;
  // Hue positions where the ramp changes segment (6t = 1, 2t = 1, 3t = 2).
  localparam int SEG_EDGES [6] = '{5461, 5462, 16383, 16384, 21845, 21846};
  localparam int HUE_SHIFTS [3] = '{0, 10922, 21846};

  typedef struct packed {
    logic [W-1:0] red;
    logic [W-1:0] green;
    logic [W-1:0] blue;
  } rgb_t;

  class pixel_scoreboard;
    rgb_t pending_rgb[$];
    int   errors;
    int   compared;

    function new();
      errors = 0;
      compared = 0;
    endfunction

    function longint clamp_unit(longint v);
      if (v < 0) return 0;
      if (v > UNIT) return UNIT;
      return v;
    endfunction

    // Piecewise hue ramp between p and q at wrapped offset t.
    function logic [W-1:0] ramp_at(longint p, longint q, longint t);
      longint d;
      longint v;
      hsl_pkg::seg_t seg;
      d = q - p;
      if (6 * t < UNIT) seg = hsl_pkg::SEG_RISE;
      else if (2 * t < UNIT) seg = hsl_pkg::SEG_HIGH;
      else if (3 * t < 2 * UNIT) seg = hsl_pkg::SEG_FALL;
      else seg = hsl_pkg::SEG_LOW;
      case (seg)
        hsl_pkg::SEG_RISE: v = p + (d * 6 * t) / UNIT;
        hsl_pkg::SEG_HIGH: v = q;
        hsl_pkg::SEG_FALL: v = p + (d * (4 * UNIT - 6 * t)) / UNIT;
        default:           v = p;
      endcase
      return W'(clamp_unit(v));
    endfunction

    function rgb_t rgb_of_hsl(logic [W-1:0] hue, logic [W-1:0] sat, logic [W-1:0] light);
      longint h;
      longint s;
      longint l;
      longint q;
      longint p;
      rgb_t   c;
      h = longint'(hue) & (UNIT - 1);
      s = clamp_unit(longint'(sat));
      l = clamp_unit(longint'(light));
      if (s == 0) begin
        c.red = W'(l);
        c.green = W'(l);
        c.blue = W'(l);
        return c;
      end
      if (2 * l < UNIT) q = (l * (UNIT + s)) / UNIT;
      else q = l + s - (l * s) / UNIT;
      p = 2 * l - q;
      c.red = ramp_at(p, q, (h + THIRD_OFF) & (UNIT - 1));
      c.green = ramp_at(p, q, h);
      c.blue = ramp_at(p, q, (h + UNIT - THIRD_OFF) & (UNIT - 1));
      return c;
    endfunction

    function void note_pixel(logic [W-1:0] hue, logic [W-1:0] sat, logic [W-1:0] light);
      pending_rgb.push_back(rgb_of_hsl(hue, sat, light));
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_SHOWN) $display("mismatch: %s", what);
    endtask

    task check_pixel(logic [W-1:0] red, logic [W-1:0] green, logic [W-1:0] blue);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        report($sformatf("color %0d/%0d/%0d with no pixel pending", red, green, blue));
        return;
      end
      want = pending_rgb.pop_front();
      if (red !== want.red)
        report($sformatf("color %0d red %0d, want %0d", compared, red, want.red));
      if (green !== want.green)
        report($sformatf("color %0d green %0d, want %0d", compared, green, want.green));
      if (blue !== want.blue)
        report($sformatf("color %0d blue %0d, want %0d", compared, blue, want.blue));
      compared++;
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_hue = '0;
  logic [W-1:0] in_saturation = '0;
  logic [W-1:0] in_lightness = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_red;
  logic [W-1:0] out_green;
  logic [W-1:0] out_blue;

  pixel_scoreboard sb;
  bit calm = 1'b0;
  int cycles = 0;
  int stall_left = 0;
  int sent = 0;
  int zero_sat = 0;
  int over_range = 0;

  hsl_to_rgb_converter_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [W-1:0] hue_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return W'((SEG_EDGES[$urandom_range(0, 5)] + HUE_SHIFTS[$urandom_range(0, 2)]
                 + $urandom_range(0, 4) - 2) & (UNIT - 1));
    if (r < 20) return ($urandom_range(0, 1) != 0) ? W'(UNIT) : '0;
    return W'($urandom_range(0, UNIT));
  endfunction

  function automatic logic [W-1:0] level_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return W'(UNIT);
    if (r < 24) return W'($urandom_range(UNIT / 2 - 1, UNIT / 2 + 1));
    if (r < 28) return ($urandom_range(0, 1) != 0) ? W'(1) : W'(UNIT - 1);
    return W'($urandom_range(0, UNIT));
  endfunction

  // Every accepted pixel gets its expected color queued.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_hue, in_saturation, in_lightness);
  end

  // Result side: check each transfer, then pick the next stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_red, out_green, out_blue);
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        stall_left = $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colors outstanding", cycles,
               sb.pending_rgb.size());
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_pixel(input logic [W-1:0] h, input logic [W-1:0] s,
                            input logic [W-1:0] l);
    int gap;
    in_valid <= 1'b1;
    in_hue <= h;
    in_saturation <= s;
    in_lightness <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (s == 0) zero_sat++;
    if (h > UNIT || s > UNIT || l > UNIT) over_range++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_random(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_pixel(hue_value(), '0, level_value());
      else if (r < 25)
        send_pixel(W'($urandom_range(0, 65535)), W'($urandom_range(0, 65535)),
                   W'($urandom_range(0, 65535)));
      else send_pixel(hue_value(), level_value(), level_value());
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_rgb.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gray pixels, including a lightness above one.
    send_pixel(16'd0, 16'd0, 16'd0);
    send_pixel(16'd12345, 16'd0, 16'd20000);
    send_pixel(16'd0, 16'd0, 16'd32768);
    send_pixel(16'd65535, 16'd0, 16'd65535);
    // Full saturation at half lightness, hue swept over the segment edges.
    send_pixel(16'd0, 16'd32768, 16'd16384);
    send_pixel(16'd5461, 16'd32768, 16'd16384);
    send_pixel(16'd5462, 16'd32768, 16'd16384);
    send_pixel(16'd10922, 16'd32768, 16'd16384);
    send_pixel(16'd10923, 16'd32768, 16'd16384);
    send_pixel(16'd16383, 16'd32768, 16'd16384);
    send_pixel(16'd16384, 16'd32768, 16'd16384);
    send_pixel(16'd21845, 16'd32768, 16'd16384);
    send_pixel(16'd21846, 16'd32768, 16'd16384);
    send_pixel(16'd27306, 16'd32768, 16'd16384);
    send_pixel(16'd32767, 16'd32768, 16'd16384);
    // Hue of one and above wraps around.
    send_pixel(16'd32768, 16'd32768, 16'd16384);
    send_pixel(16'd49152, 16'd32768, 16'd16384);
    send_pixel(16'd65535, 16'd32768, 16'd16384);
    // Lightness on either side of one half, and saturation above one.
    send_pixel(16'd3000, 16'd32768, 16'd16383);
    send_pixel(16'd3000, 16'd20000, 16'd30000);
    send_pixel(16'd3000, 16'd65535, 16'd65535);
    send_pixel(16'd20000, 16'd1, 16'd1);
    send_pixel(16'd7000, 16'd40000, 16'd0);
    send_pixel(16'd1000, 16'd16384, 16'd32768);

    run_random(500);
    // Let the pipeline empty completely before going on.
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    calm = 1'b1;
    run_random(300);
    calm = 1'b0;
    run_random(650);
    // The wait for the clock edge lets the last transfer reach the scoreboard before the drain wait.
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d pixels (%0d gray, %0d with fields above one), checked %0d colors",
             sent, zero_sat, over_range, sb.compared);
    $display("random idling on both sides, one full drain, one stretch at full rate");
    if (sb.errors == 0 && sb.pending_rgb.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d colors never arrived", sb.errors, sb.pending_rgb.size());
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/hsl_pkg.sv
src/hsl_pq.sv
src/hsl_ramp.sv
src/hsl_to_rgb_converter_core.sv
verif/testbench.sv
